// File: src/bfm_pkg.sv
// Package for the barcode frame module mapper: word types, result codes,
// the reserved-region bounds and the controller/datapath command and status.
// No dependencies.
package bfm_pkg;

  // Result codes
  localparam logic [1:0] RK_MODULE  = 2'd0;
  localparam logic [1:0] RK_KEPT    = 2'd1;
  localparam logic [1:0] RK_DROPPED = 2'd2;

  // Input kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Reset value of the frame limit register
  localparam logic [15:0] FRAME_LIMIT_RST = 16'd20;

  // Reserved-region bounds (finder, alignment, short last column)
  localparam logic [7:0] FINDER_SPAN   = 8'd8;
  localparam logic [7:0] FINDER_FAR    = 8'd135;
  localparam logic [7:0] ALIGN_LOW     = 8'd123;
  localparam logic [7:0] ALIGN_HIGH    = 8'd141;
  localparam logic [7:0] SHORT_COL     = 8'd143;
  localparam logic [7:0] SHORT_COL_ROW = 8'd56;
  // Page number rows in column 0 run up to here (exclusive)
  localparam logic [7:0] PAGE_ROW_END  = 8'd16;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  column;
    logic [7:0]  grid_row;
    logic        dark;
    logic [15:0] frame_number;
    logic        last;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // load the byte register
    logic load_zero;   // load a zero pad byte instead of input data
    logic emit_mod;    // emit a module word for the current position
    logic emit_frame;  // emit a frame word (kept or dropped)
    logic closing;     // frame word closes the stream: no page step, stop after
    logic consume;     // shift the byte register by one bit
    logic advance;     // step to the next grid position
    logic last;        // last word caused by the current input
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;        // current position is reserved
    logic page_pos;    // current position carries a page number bit
    logic wrap;        // current position is the last of the grid
    logic over;        // one more kept frame would pass the limit
    logic stopped;     // block has stopped
    logic out_free;    // output register can take a word this cycle
  } sts_t;

endpackage

// File: src/bfm_ctrl.sv
// Controller for the barcode frame module mapper: input handshake and the
// sequence of position visits and frame words. Depends on bfm_pkg.
module bfm_ctrl
  import bfm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_stall,
  input  sts_t     sts,
  output cmd_t     cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_VISIT = 2'd1;
  localparam logic [1:0] S_FRAME = 2'd2;
  localparam logic [1:0] S_CLOSE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] bits_left_r, bits_left_nxt;
  logic       is_end_r, is_end_nxt;
  logic       more_pad_r, more_pad_nxt;
  logic       byte_done_r, byte_done_nxt;
  logic       in_accept;
  logic       bit_taken;
  logic       done_now;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    bits_left_nxt = bits_left_r;
    is_end_nxt    = is_end_r;
    more_pad_nxt  = more_pad_r;
    byte_done_nxt = byte_done_r;
    cmd           = '0;
    bit_taken     = !sts.skip && !sts.page_pos;
    done_now      = bit_taken && (bits_left_r == 4'd1);
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && !sts.stopped) begin
          cmd.load      = 1'b1;
          cmd.load_zero = (in_kind == KIND_END);
          bits_left_nxt = 4'd8;
          is_end_nxt    = (in_kind == KIND_END);
          more_pad_nxt  = (in_kind == KIND_END);
          state_nxt     = S_VISIT;
        end
      end
      S_VISIT: begin
        if (sts.skip || sts.out_free) begin
          cmd.emit_mod = !sts.skip;
          cmd.last     = done_now && !sts.wrap && !is_end_r;
          cmd.consume  = bit_taken;
          cmd.advance  = 1'b1;
          if (bit_taken) begin
            bits_left_nxt = bits_left_r - 4'd1;
          end
          byte_done_nxt = done_now;
          if (sts.wrap) begin
            state_nxt = S_FRAME;
          end else if (done_now) begin
            if (!is_end_r) begin
              state_nxt = S_IDLE;
            end else if (more_pad_r) begin
              cmd.load      = 1'b1;
              cmd.load_zero = 1'b1;
              bits_left_nxt = 4'd8;
              more_pad_nxt  = 1'b0;
            end else begin
              state_nxt = S_CLOSE;
            end
          end
        end
      end
      S_FRAME: begin
        if (sts.out_free) begin
          cmd.emit_frame = 1'b1;
          if (sts.over) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.last = byte_done_r && !is_end_r;
            if (!byte_done_r) begin
              state_nxt = S_VISIT;
            end else if (!is_end_r) begin
              state_nxt = S_IDLE;
            end else if (more_pad_r) begin
              cmd.load      = 1'b1;
              cmd.load_zero = 1'b1;
              bits_left_nxt = 4'd8;
              more_pad_nxt  = 1'b0;
              state_nxt     = S_VISIT;
            end else begin
              state_nxt = S_CLOSE;
            end
          end
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.emit_frame = 1'b1;
          cmd.closing    = 1'b1;
          cmd.last       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bits_left_r <= '0;
      is_end_r    <= 1'b0;
      more_pad_r  <= 1'b0;
      byte_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bits_left_r <= bits_left_nxt;
      is_end_r    <= is_end_nxt;
      more_pad_r  <= more_pad_nxt;
      byte_done_r <= byte_done_nxt;
    end
  end

  // Words only go out when the output register can take them
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_mod || cmd.emit_frame) |-> sts.out_free)
    else $error("word emitted into a full output register");

  // A module word and a frame word never share a cycle
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_mod && cmd.emit_frame))
    else $error("two words emitted in one cycle");

  // Inputs taken while stopped start no walk
  a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_accept && sts.stopped) |=> (state_r == S_IDLE))
    else $error("walk started while stopped");

  // A walk always has data bits still to place
  a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VISIT) |-> (bits_left_r != 4'd0))
    else $error("visiting with no bits left");

endmodule

// File: src/bfm_dp.sv
// Datapath for the barcode frame module mapper: grid position, page and
// frame counters, byte shifter, limit register and output word register.
// Depends on bfm_pkg.
module bfm_dp
  import bfm_pkg::*;
#(
  parameter int GRID_SIZE = 144
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [7:0] in_byte,
  input  logic      cfg_we,
  input  logic [15:0] cfg_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic [7:0] LAST_POS = 8'(GRID_SIZE - 1);

  logic [7:0]  col_r, row_r;
  logic [15:0] page_r, frames_r, limit_r;
  logic        stopped_r;
  logic [7:0]  byte_r;
  logic        out_valid_r;
  out_word_t   out_data_r;
  logic [16:0] frames_inc;
  logic        skip;
  logic        keep;

  // Reserved positions
  always_comb begin
    skip = 1'b0;
    if (col_r < FINDER_SPAN && (row_r < FINDER_SPAN || row_r > FINDER_FAR)) skip = 1'b1;
    if (col_r > FINDER_FAR && row_r < FINDER_SPAN) skip = 1'b1;
    if (col_r > ALIGN_LOW && col_r < ALIGN_HIGH &&
        row_r > ALIGN_LOW && row_r < ALIGN_HIGH) skip = 1'b1;
    if (col_r == SHORT_COL && row_r > SHORT_COL_ROW) skip = 1'b1;
  end

  assign frames_inc   = {1'b0, frames_r} + 17'd1;
  assign keep         = !sts.over;
  assign sts.skip     = skip;
  assign sts.page_pos = (col_r == 8'd0) && (row_r < PAGE_ROW_END);
  assign sts.wrap     = (col_r == LAST_POS) && (row_r == LAST_POS);
  assign sts.over     = frames_inc > {1'b0, limit_r};
  assign sts.stopped  = stopped_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  // Walk position, counters and stop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      page_r    <= 16'd1;
      frames_r  <= '0;
      stopped_r <= 1'b0;
    end else begin
      if (cmd.advance) begin
        if (row_r == LAST_POS) begin
          row_r <= '0;
          col_r <= (col_r == LAST_POS) ? 8'd0 : col_r + 8'd1;
        end else begin
          row_r <= row_r + 8'd1;
        end
      end
      if (cmd.emit_frame) begin
        if (keep) begin
          frames_r <= frames_inc[15:0];
          if (!cmd.closing) begin
            page_r <= page_r + 16'd1;
          end
        end
        if (!keep || cmd.closing) begin
          stopped_r <= 1'b1;
        end
      end
    end
  end

  // Byte shifter, bit 0 placed first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= cmd.load_zero ? 8'd0 : in_byte;
    end else if (cmd.consume) begin
      byte_r <= {1'b0, byte_r[7:1]};
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_mod || cmd.emit_frame) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mod) begin
      out_data_r.result_kind  <= RK_MODULE;
      out_data_r.column       <= col_r;
      out_data_r.grid_row     <= row_r;
      out_data_r.dark         <= sts.page_pos ? page_r[row_r[2:0]] : byte_r[0];
      out_data_r.frame_number <= page_r;
      out_data_r.last         <= cmd.last;
    end else if (cmd.emit_frame) begin
      out_data_r.result_kind  <= keep ? RK_KEPT : RK_DROPPED;
      out_data_r.column       <= '0;
      out_data_r.grid_row     <= '0;
      out_data_r.dark         <= 1'b0;
      out_data_r.frame_number <= page_r;
      out_data_r.last         <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/barcode_frame_module_mapper.sv
// Barcode frame module mapper: places data bytes, bit 0 first, on a module grid
// column by column and reports each module, then each finished frame.
// One grid position is visited per clock while no output word is held up. A
// data byte's walk places its eight bits, also visiting page-number positions,
// which take no data bit, and passing reserved ones; it adds a frame word when
// the walk crosses the end of the grid, then returns to idle to accept the next
// byte. An end word walks two zero pad bytes and then closes the frame. Output
// back-pressure holds the walk only where a word is due; the input is stalled
// for the whole walk of one byte. Inputs taken after the block stops cause no
// words. Depends on bfm_pkg, bfm_ctrl and bfm_dp.
module barcode_frame_module_mapper
  import bfm_pkg::*;
#(
  parameter int GRID_SIZE = 144
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Limit register is always writable
  assign cfg_ready = 1'b1;

  bfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfm_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_data.data_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
